// File: sv/lbsd_pkg.sv
// ----------------------------------------------------------------------------
// lbsd_pkg
// Types, seeds and single-bit LFSR steps shared by the block scrambler and
// its result queue.
// ----------------------------------------------------------------------------
package lbsd_pkg;

	localparam int unsigned SR_W = 9;
	localparam int unsigned SKIP_BITS = 5;
	localparam int unsigned FLUSH_BITS = 5;
	localparam int unsigned KEEP_BITS = 8 - SKIP_BITS;

	localparam logic [SR_W-1:0] TX_SEED = 9'h00f;
	localparam logic [SR_W-1:0] RX_SEED = 9'h1f0;

	localparam logic MODE_SCRAMBLE = 1'b0;
	localparam logic MODE_DESCRAMBLE = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

	// Up to two result items pushed into the queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		result_t    e0;
		result_t    e1;
	} push_t;

	// Scrambler step: returns {output bit, next register}
	function automatic logic [SR_W:0] scr_step(input logic [SR_W-1:0] s, input logic b);
		logic [SR_W-1:0] nxt;
		nxt = {b ^ s[0], s[8:1]};
		nxt[3] = s[4] ^ s[0];
		return {s[4] ^ s[0], nxt};
	endfunction

	// Descrambler step: returns {output bit, next register}
	function automatic logic [SR_W:0] dscr_step(input logic [SR_W-1:0] s, input logic b);
		logic [SR_W-1:0] nxt;
		nxt = {b, s[8:1]};
		nxt[3] = s[4] ^ b;
		return {b ^ s[0], nxt};
	endfunction

endpackage

// File: sv/lbsd_fifo.sv
// ----------------------------------------------------------------------------
// lbsd_fifo
// Four-entry result queue; takes zero, one or two items per cycle and
// hands out one item per cycle on a valid/ready channel.
// ----------------------------------------------------------------------------
module lbsd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  lbsd_pkg::push_t  push,
	output logic             room2,
	output logic             out_valid,
	input  logic             out_ready,
	output lbsd_pkg::result_t out_item
);
	import lbsd_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.e0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

endmodule

// File: sv/lfsr_block_scrambler_descrambler.sv
// ----------------------------------------------------------------------------
// lfsr_block_scrambler_descrambler
// 9-bit LFSR block scrambler (mode 0) and descrambler (mode 1), one byte
// per item, with per-block seeding, lead-bit skip and tail flush.
// ----------------------------------------------------------------------------
// Input bytes are registered, then the whole byte (plus five flush bits on a
// block's last byte when scrambling) goes through the unrolled LFSR
// combinationally and its results drop into a four-entry queue. One input
// item per cycle is sustained while the queue has room for two items. When
// scrambling, the first byte of a multi-byte block yields no result and its
// last byte yields two, so the output port, at most one item per cycle, sets
// the rate over a block. Writing mode abandons any block in progress; write
// it only while the block is idle.
module lfsr_block_scrambler_descrambler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       block_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_byte,
	output logic       result_last
);
	import lbsd_pkg::*;

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                mode_q;
	logic [SR_W-1:0]     sr_q;
	logic [KEEP_BITS-1:0] acc_q;
	logic                start_q;

	logic                room2;
	logic                adv;
	push_t               push;
	result_t             out_item;

	logic [SR_W-1:0]     sr_c;
	logic [SR_W:0]       stp;
	logic [7:0]          sb;
	logic [FLUSH_BITS-1:0] fb;
	logic [SR_W-1:0]     sr_next;

	assign adv      = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= block_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_comb begin
		sr_c = sr_q;
		if (start_q) begin
			sr_c = (mode_q == MODE_DESCRAMBLE) ? RX_SEED : TX_SEED;
		end
		sb = '0;
		fb = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mode_q == MODE_DESCRAMBLE) begin
				stp = dscr_step(sr_c, data_s1[i]);
			end else begin
				stp = scr_step(sr_c, data_s1[i]);
			end
			sb[i] = stp[SR_W];
			sr_c  = stp[SR_W-1:0];
		end
		sr_next = sr_c;
		for (int j = FLUSH_BITS - 1; j >= 0; j--) begin
			stp   = scr_step(sr_c, 1'b0);
			fb[j] = stp[SR_W];
			sr_c  = stp[SR_W-1:0];
		end

		push = '0;
		if (adv) begin
			if (mode_q == MODE_DESCRAMBLE) begin
				push.n  = 2'd1;
				push.e0 = '{data: sb, last: last_s1};
			end else if (start_q) begin
				push.n  = last_s1 ? 2'd1 : 2'd0;
				push.e0 = '{data: {sb[KEEP_BITS-1:0], fb}, last: 1'b1};
			end else begin
				push.n  = last_s1 ? 2'd2 : 2'd1;
				push.e0 = '{data: {acc_q, sb[7:KEEP_BITS]}, last: 1'b0};
				push.e1 = '{data: {sb[KEEP_BITS-1:0], fb}, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SCRAMBLE;
			sr_q    <= TX_SEED;
			acc_q   <= '0;
			start_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q  <= cfg_wdata;
			acc_q   <= '0;
			start_q <= 1'b1;
		end else if (adv) begin
			sr_q    <= sr_next;
			acc_q   <= sb[KEEP_BITS-1:0];
			start_q <= last_s1;
		end
	end

	lbsd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign result_byte = out_item.data;
	assign result_last = out_item.last;

endmodule
